### hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Check that a condition holds in the cycle after a trigger.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### hw/rtl/tts_pkg.sv
// Shared types and codes for the tick scheduler.
// Depends on nothing.
package tts_pkg;
  localparam logic [3:0] OP_TICK = 4'd0;
  localparam logic [3:0] OP_SET_STATE = 4'd1;
  localparam logic [3:0] OP_WAIT = 4'd2;
  localparam logic [3:0] OP_WAIT_SEM = 4'd3;
  localparam logic [3:0] OP_SIGNAL = 4'd4;
  localparam logic [3:0] OP_PRESET = 4'd5;
  localparam logic [3:0] OP_START = 4'd6;
  localparam logic [3:0] OP_OPEN = 4'd7;
  localparam logic [3:0] OP_PUT = 4'd8;
  localparam logic [3:0] OP_GET = 4'd9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BLOCK = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [2:0] COND_IDLE = 3'd0;
  localparam logic [2:0] COND_READY = 3'd1;
  localparam logic [2:0] COND_SEM = 3'd2;
  localparam logic [2:0] COND_TIME = 3'd4;

  localparam logic [1:0] EV_RESET = 2'd0;
  localparam logic [1:0] EV_SIGNAL = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;

  localparam int MAX_RESULTS = 16;
  localparam logic [6:0] INDEX_MASK = 7'h7F;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_RDWAIT, S_TICK, S_EMIT, S_OUT
  } state_t;
endpackage

### hw/rtl/tts_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/tick_task_scheduler_with_semaphores_unit.sv
// Cooperative tick scheduler with counting semaphores and byte queues.
// Channels: in_* carries one operation per transaction; out_* returns results,
// out_last marking the final result of an operation. Non-tick operations give
// one result; a tick gives one result per dispatched task (at most 16) or one
// empty result.
// Sequence: a non-tick operation is worked in S_OP and its result shown in
// S_OUT; get passes through S_RDWAIT between them, waiting on the queue store's
// registered read. A tick walks the task table from entry 0 until the next entry
// is idle or the table ends, one entry at a time through one shared update unit:
// S_TICK updates the entry, S_EMIT shows the dispatch held from an earlier entry
// or moves on. After the walk, S_EMIT loads the held dispatch as the final result,
// or an empty result, and S_OUT shows it. The block takes one operation at a time
// and is ready again the cycle after its last result.
// in_ready is low while an operation is being worked and while a result waits.
// Reset clears all task, semaphore and queue pointer state; the queue store
// keeps whatever it held. When the receiver stalls, the shown result holds and
// the walk pauses until it is taken.
module tick_task_scheduler_with_semaphores_unit import tts_pkg::*; #(
  parameter int TASK_SLOTS = 16,
  parameter int SEM_SLOTS = 16,
  parameter int QUEUE_COUNT = 4,
  parameter int QUEUE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_opcode,
  input  logic [3:0]  in_caller_task,
  input  logic [3:0]  in_target_index,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_timeout_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic [3:0]  out_task_index,
  output logic [7:0]  out_task_state,
  output logic [1:0]  out_task_event,
  output logic        out_dispatch_valid,
  output logic        out_last
);
  localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int SW = $clog2(SEM_SLOTS);
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int AW = $clog2(QUEUE_COUNT * QUEUE_DEPTH);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  // Task table and semaphores
  logic [2:0]  cond_r  [TASK_SLOTS];
  logic [7:0]  ustate_r[TASK_SLOTS];
  logic [1:0]  event_r [TASK_SLOTS];
  logic [SW-1:0] wsem_r[TASK_SLOTS];
  logic [15:0] timer_r [TASK_SLOTS];
  logic [CW-1:0] alloc_r;
  logic [7:0]  sem_r   [SEM_SLOTS];
  logic [PW-1:0] head_r[QUEUE_COUNT];
  logic [PW-1:0] tail_r[QUEUE_COUNT];

  // Captured operation
  logic [3:0]  op_r, caller_r, idx_r;
  logic [7:0]  byte_r;
  logic [15:0] tmo_r;

  state_t state_r, state_nxt;
  logic [TW-1:0] walk_r;
  logic [NW-1:0] nres_r;
  logic          pend_r;       // an earlier dispatch is shown, not final
  logic          pmore_r;      // walk continues after the pending dispatch
  logic          held_r;       // latest dispatch found, not yet shown
  logic [3:0]    h_tidx_r;
  logic [7:0]    h_state_r;
  logic [1:0]    h_event_r;
  logic [1:0]  o_status_r;
  logic [7:0]  o_byte_r;
  logic [3:0]  o_tidx_r;
  logic [7:0]  o_state_r;
  logic [1:0]  o_event_r;
  logic        o_dv_r, o_last_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  tts_ram #(.WIDTH(8), .DEPTH(QUEUE_COUNT * QUEUE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Operand checks
  logic caller_ok, sem_ok, queue_ok;
  logic [TW-1:0] ct;
  logic [SW-1:0] si;
  logic [QW-1:0] qi;
  logic [SW-1:0] take_s;
  logic [SW-1:0] give_s;
  logic          give_ok;
  always_comb begin
    caller_ok = {28'd0, caller_r} < 32'(TASK_SLOTS);
    sem_ok    = {28'd0, idx_r} < 32'(SEM_SLOTS);
    queue_ok  = ({28'd0, idx_r} < 32'(QUEUE_COUNT)) &&
                ({28'd0, idx_r} + 32'(QUEUE_COUNT) < 32'(SEM_SLOTS));
    ct = caller_r[TW-1:0];
    si = SW'(idx_r);
    qi = QW'(idx_r);
    take_s = (op_r == OP_GET) ? SW'(32'(idx_r) + 32'(QUEUE_COUNT)) : si;
    give_s = (op_r == OP_PUT) ? SW'(32'(idx_r) + 32'(QUEUE_COUNT)) : si;
    give_ok = (op_r == OP_PUT) ? (32'(idx_r) + 32'(QUEUE_COUNT) < 32'(SEM_SLOTS)) : 1'b1;
  end

  logic take_ok;
  assign take_ok = sem_r[take_s] != 8'd0;

  // Walk step of the entry under the cursor
  logic [2:0]  w_cond;
  logic [1:0]  w_ev;
  logic [15:0] w_tmr;
  logic        w_dec;
  logic [SW-1:0] w_s;
  logic        w_last;
  always_comb begin
    w_cond = cond_r[walk_r];
    w_ev   = event_r[walk_r];
    w_tmr  = timer_r[walk_r];
    w_s    = wsem_r[walk_r];
    w_dec  = 1'b0;
    if ((w_cond & COND_SEM) != 3'd0 && sem_r[w_s] != 8'd0) begin
      w_dec  = 32'(w_s) >= 2 * QUEUE_COUNT;
      w_ev   = EV_SIGNAL;
      w_cond = COND_READY;
    end
    if ((w_cond & COND_TIME) != 3'd0 && w_tmr != 16'd0) begin
      w_tmr = w_tmr - 16'd1;
      if (w_tmr == 16'd0) begin
        w_ev   = EV_TIMEOUT;
        w_cond = COND_READY;
      end
    end
    w_last = (32'(walk_r) + 1 >= TASK_SLOTS) ||
             (cond_r[(32'(walk_r) + 1 >= TASK_SLOTS) ? '0 : TW'(32'(walk_r) + 1)]
              == COND_IDLE);
  end

  // Store address
  always_comb begin
    ram_we = 1'b0;
    ram_wdata = byte_r;
    ram_addr = {qi, (op_r == OP_PUT) ? head_r[qi] : tail_r[qi]};
    if (state_r == S_OP && op_r == OP_PUT && caller_ok && queue_ok && take_ok) begin
      ram_we = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = (in_opcode == OP_TICK) ? S_TICK : S_OP;
      S_OP:     state_nxt = (op_r == OP_GET && caller_ok && queue_ok && take_ok) ?
                            S_RDWAIT : S_OUT;
      S_RDWAIT: state_nxt = S_OUT;
      S_TICK:   state_nxt = S_EMIT;
      S_EMIT: begin
        if (!pend_r) begin
          state_nxt = pmore_r ? S_TICK : S_OUT;
        end else if (out_ready) begin
          state_nxt = pmore_r ? S_TICK : S_EMIT;
        end
      end
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = state_r == S_IDLE;
    out_valid = (state_r == S_OUT) || (state_r == S_EMIT && pend_r);
    out_status = o_status_r;
    out_read_byte = o_byte_r;
    out_task_index = o_tidx_r;
    out_task_state = o_state_r;
    out_task_event = o_event_r;
    out_dispatch_valid = o_dv_r;
    out_last = o_last_r;
  end

  // Datapath and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      alloc_r <= '0;
      walk_r  <= '0;
      nres_r  <= '0;
      pend_r  <= 1'b0;
      pmore_r <= 1'b0;
      held_r  <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        cond_r[i] <= COND_IDLE;
        ustate_r[i] <= '0;
        event_r[i] <= EV_RESET;
        wsem_r[i] <= '0;
        timer_r[i] <= '0;
      end
      for (int i = 0; i < SEM_SLOTS; i++) sem_r[i] <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_opcode;
            caller_r <= in_caller_task;
            idx_r <= in_target_index;
            byte_r <= in_byte_value;
            tmo_r <= in_timeout_ticks;
            walk_r <= '0;
            nres_r <= '0;
            pend_r <= 1'b0;
            held_r <= 1'b0;
          end
        end
        S_OP: begin
          o_status_r <= ST_OK;
          o_byte_r <= '0;
          o_tidx_r <= '0;
          o_state_r <= '0;
          o_event_r <= EV_RESET;
          o_dv_r <= 1'b0;
          o_last_r <= 1'b1;
          case (op_r)
            OP_SET_STATE:
              if (caller_ok) ustate_r[ct] <= byte_r;
              else o_status_r <= ST_BAD;
            OP_WAIT:
              if (caller_ok) begin
                timer_r[ct] <= tmo_r;
                cond_r[ct] <= COND_TIME;
              end else o_status_r <= ST_BAD;
            OP_SIGNAL:
              if (sem_ok) begin
                if (sem_r[si] != 8'd255) sem_r[si] <= sem_r[si] + 8'd1;
              end else o_status_r <= ST_BAD;
            OP_PRESET:
              if (sem_ok) sem_r[si] <= byte_r;
              else o_status_r <= ST_BAD;
            OP_START:
              if (32'(alloc_r) < TASK_SLOTS) begin
                cond_r[alloc_r[TW-1:0]] <= COND_READY;
                ustate_r[alloc_r[TW-1:0]] <= '0;
                event_r[alloc_r[TW-1:0]] <= EV_RESET;
                timer_r[alloc_r[TW-1:0]] <= '0;
                alloc_r <= alloc_r + CW'(1);
                o_tidx_r <= 4'(alloc_r);
              end else o_status_r <= ST_BAD;
            OP_OPEN:
              if (queue_ok) begin
                head_r[qi] <= '0;
                tail_r[qi] <= '0;
                sem_r[si] <= 8'(QUEUE_DEPTH);
                o_tidx_r <= idx_r;
              end else o_status_r <= ST_BAD;
            OP_WAIT_SEM, OP_PUT, OP_GET: begin
              if (!caller_ok || (op_r == OP_WAIT_SEM ? !sem_ok : !queue_ok)) begin
                o_status_r <= ST_BAD;
              end else if (take_ok) begin
                sem_r[take_s] <= sem_r[take_s] - 8'd1;
                cond_r[ct] <= COND_READY;
                if (op_r != OP_WAIT_SEM) begin
                  if (op_r == OP_PUT) head_r[qi] <= head_r[qi] + PW'(1);
                  else tail_r[qi] <= tail_r[qi] + PW'(1);
                  // give the partner semaphore; distinct from the taken one
                  if (give_ok && sem_r[op_r == OP_PUT ? give_s : si] != 8'd255)
                    sem_r[op_r == OP_PUT ? give_s : si] <=
                      sem_r[op_r == OP_PUT ? give_s : si] + 8'd1;
                end
              end else begin
                o_status_r <= ST_BLOCK;
                wsem_r[ct] <= take_s;
                if (tmo_r != 16'd0) begin
                  timer_r[ct] <= tmo_r;
                  cond_r[ct] <= COND_SEM | COND_TIME;
                end else cond_r[ct] <= COND_SEM;
              end
            end
            default: o_status_r <= ST_BAD;
          endcase
        end
        S_RDWAIT: o_byte_r <= ram_rdata;
        S_TICK: begin
          cond_r[walk_r] <= w_cond;
          event_r[walk_r] <= w_ev;
          timer_r[walk_r] <= w_tmr;
          if (w_dec) sem_r[w_s] <= sem_r[w_s] - 8'd1;
          pmore_r <= !w_last;
          walk_r <= walk_r + TW'(1);
          pend_r <= 1'b0;
          if (w_cond == COND_READY && 32'(nres_r) < MAX_RESULTS) begin
            // hold the new dispatch; show the one held before, which is not final
            held_r <= 1'b1;
            nres_r <= nres_r + NW'(1);
            h_tidx_r <= 4'(walk_r);
            h_state_r <= ustate_r[walk_r];
            h_event_r <= w_ev;
            if (held_r) begin
              pend_r <= 1'b1;
              o_status_r <= ST_OK;
              o_byte_r <= '0;
              o_tidx_r <= h_tidx_r;
              o_state_r <= h_state_r;
              o_event_r <= h_event_r;
              o_dv_r <= 1'b1;
              o_last_r <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          if (pend_r) begin
            if (out_ready) pend_r <= 1'b0;
          end else if (!pmore_r) begin
            // walk done: show the held dispatch as final, or an empty result
            o_status_r <= ST_OK;
            o_byte_r <= '0;
            o_last_r <= 1'b1;
            if (held_r) begin
              o_tidx_r <= h_tidx_r;
              o_state_r <= h_state_r;
              o_event_r <= h_event_r;
              o_dv_r <= 1'b1;
            end else begin
              o_tidx_r <= '0;
              o_state_r <= '0;
              o_event_r <= EV_RESET;
              o_dv_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### hw/rtl/tts_checker.sv
// Port-level checker for the tick scheduler, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module tts_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic out_dispatch_valid,
  input logic out_last
);
  // Never take a new transaction while a result is shown
  `CHK_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // Dispatch results report success
  `CHK_IMPLY(a_disp_ok, clk, rst_n, out_valid && out_dispatch_valid, out_status == 2'd0)
  // An accepted operation leaves the block busy next cycle
  `CHK_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  // A non-dispatch result always closes its operation
  `CHK_IMPLY(a_nd_last, clk, rst_n, out_valid && !out_dispatch_valid, out_last)
endmodule

bind tick_task_scheduler_with_semaphores_unit tts_checker u_tts_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_dispatch_valid(out_dispatch_valid), .out_last(out_last)
);
